// ----- src/aes3pcm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// AES3 element to PCM: shared package
// Types and constants used by the configuration, parser and output stages.
// ---------------------------------------------------------------------------
package aes3pcm_pkg;

  // Channel words per sample group and the header position reached once
  // the parser is in the payload.
  localparam int unsigned CHANNELS      = 8;
  localparam int unsigned CH_W          = $clog2(CHANNELS);
  localparam logic [2:0]  HDR_PAYLOAD   = 3'd4;
  localparam logic [1:0]  WORD_LAST_POS = 2'd3;

  // Sample size code that selects 16-bit output. Every other code means 24.
  localparam logic [1:0]  SAMPLE_BYTES_16 = 2'd2;

  // Register reset values.
  localparam logic [1:0]  SAMPLE_BYTES_RST  = 2'd3;
  localparam logic [3:0]  LEAD_CHANNELS_RST = 4'd8;
  localparam logic [3:0]  LEAD_CHANNELS_MAX = 4'd8;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_SAMPLE_BYTES        = 2'd0,
    REG_SINGLE_CHANNEL_MODE = 2'd1,
    REG_SELECTED_CHANNEL    = 2'd2,
    REG_LEAD_CHANNELS       = 2'd3
  } cfg_reg_t;

  // Current register contents as seen by the parser.
  typedef struct packed {
    logic [1:0]      sample_bytes;
    logic            single_channel_mode;
    logic [CH_W-1:0] selected_channel;
    logic [3:0]      lead_channels;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic            last_of_element;
    logic [CH_W-1:0] channel_index;
    logic [23:0]     pcm_sample;
  } result_t;

endpackage : aes3pcm_pkg
`default_nettype wire

// ----- src/aes3pcm_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// AES3 element to PCM: configuration registers
// Holds the four control registers written through the plain write port.
// ---------------------------------------------------------------------------
module aes3pcm_cfg
  import aes3pcm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [1:0] cfg_index,
  input  wire logic [3:0] cfg_wdata,
  output cfg_t            cfg
);

  cfg_t cfg_reg;

  // Register file update, one register per write.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.sample_bytes        <= SAMPLE_BYTES_RST;
      cfg_reg.single_channel_mode <= 1'b0;
      cfg_reg.selected_channel    <= '0;
      cfg_reg.lead_channels       <= LEAD_CHANNELS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_SAMPLE_BYTES:        cfg_reg.sample_bytes        <= cfg_wdata[1:0];
        REG_SINGLE_CHANNEL_MODE: cfg_reg.single_channel_mode <= cfg_wdata[0];
        REG_SELECTED_CHANNEL:    cfg_reg.selected_channel    <= cfg_wdata[CH_W-1:0];
        REG_LEAD_CHANNELS:       cfg_reg.lead_channels       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_reg;

endmodule : aes3pcm_cfg
`default_nettype wire

// ----- src/aes3pcm_parse.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// AES3 element to PCM: element parser
// Tracks header and channel-word position per byte and forms the PCM sample
// when the fourth byte of a channel word arrives.
// ---------------------------------------------------------------------------
module aes3pcm_parse
  import aes3pcm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] element_byte,
  input  wire logic       element_start,
  input  cfg_t            cfg,
  output logic            res_valid,
  output result_t         res
);

  logic [2:0]      header_position,    header_position_next;
  logic [15:0]     sample_total,       sample_total_next;
  logic [7:0]      valid_mask,         valid_mask_next;
  logic [15:0]     samples_seen,       samples_seen_next;
  logic [CH_W-1:0] word_channel,       word_channel_next;
  logic [1:0]      word_byte_position, word_byte_position_next;
  logic [23:0]     word_bytes_held,    word_bytes_held_next;
  logic            element_finished,   element_finished_next;

  logic [31:0]     word;
  logic [23:0]     sample;
  logic [3:0]      limit;
  logic [CH_W-1:0] last_ch;
  logic            emit;
  logic            last;
  logic            word_done;

  // Sample extraction from the completed word.
  always_comb begin
    word = {element_byte, word_bytes_held};
    if (cfg.sample_bytes == SAMPLE_BYTES_16) begin
      sample = {8'h00, word[27:12]};
    end else begin
      sample = word[27:4];
    end
    if (!valid_mask[word_channel]) begin
      sample = '0;
    end
    limit = (cfg.lead_channels > LEAD_CHANNELS_MAX) ? LEAD_CHANNELS_MAX
                                                    : cfg.lead_channels;
    if (cfg.single_channel_mode) begin
      emit    = (word_channel == cfg.selected_channel);
      last_ch = cfg.selected_channel;
    end else begin
      emit    = ({1'b0, word_channel} < limit);
      last_ch = CH_W'(limit - 4'd1);
    end
    last = emit && (word_channel == last_ch) &&
           ({1'b0, samples_seen} + 17'd1 == {1'b0, sample_total});
  end

  // A word completes on its fourth payload byte.
  assign word_done = accept && !element_start && !element_finished &&
                     (header_position >= HDR_PAYLOAD) &&
                     (word_byte_position == WORD_LAST_POS);

  // Next state of the parser.
  always_comb begin
    header_position_next    = header_position;
    sample_total_next       = sample_total;
    valid_mask_next         = valid_mask;
    samples_seen_next       = samples_seen;
    word_channel_next       = word_channel;
    word_byte_position_next = word_byte_position;
    word_bytes_held_next    = word_bytes_held;
    element_finished_next   = element_finished;
    if (accept) begin
      if (element_start) begin
        header_position_next    = 3'd1;
        sample_total_next       = '0;
        valid_mask_next         = '0;
        samples_seen_next       = '0;
        word_channel_next       = '0;
        word_byte_position_next = '0;
        word_bytes_held_next    = '0;
        element_finished_next   = 1'b0;
      end else if (!element_finished) begin
        if (header_position < HDR_PAYLOAD) begin
          // Header bytes: sample count low, high, then the valid mask.
          case (header_position)
            3'd1: sample_total_next[7:0]  = element_byte;
            3'd2: sample_total_next[15:8] = element_byte;
            default: begin
              valid_mask_next = element_byte;
              if (sample_total == 16'd0) begin
                element_finished_next = 1'b1;
              end
            end
          endcase
          header_position_next = header_position + 3'd1;
        end else if (word_byte_position != WORD_LAST_POS) begin
          // Collect the first three bytes of a channel word.
          case (word_byte_position)
            2'd0:    word_bytes_held_next[7:0]   = element_byte;
            2'd1:    word_bytes_held_next[15:8]  = element_byte;
            default: word_bytes_held_next[23:16] = element_byte;
          endcase
          word_byte_position_next = word_byte_position + 2'd1;
        end else begin
          // Word complete: step to the next channel and count samples.
          word_byte_position_next = '0;
          word_bytes_held_next    = '0;
          word_channel_next       = word_channel + CH_W'(1);
          if (word_channel == CH_W'(CHANNELS - 1)) begin
            samples_seen_next = samples_seen + 16'd1;
            if (samples_seen + 16'd1 == sample_total) begin
              element_finished_next = 1'b1;
            end
          end
        end
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      header_position    <= '0;
      sample_total       <= '0;
      valid_mask         <= '0;
      samples_seen       <= '0;
      word_channel       <= '0;
      word_byte_position <= '0;
      word_bytes_held    <= '0;
      element_finished   <= 1'b1;
    end else begin
      header_position    <= header_position_next;
      sample_total       <= sample_total_next;
      valid_mask         <= valid_mask_next;
      samples_seen       <= samples_seen_next;
      word_channel       <= word_channel_next;
      word_byte_position <= word_byte_position_next;
      word_bytes_held    <= word_bytes_held_next;
      element_finished   <= element_finished_next;
    end
  end

  // Result toward the output buffer.
  assign res_valid           = word_done && emit;
  assign res.pcm_sample      = sample;
  assign res.channel_index   = word_channel;
  assign res.last_of_element = last;

`ifndef NO_ASSERTIONS
  // A start byte always reopens header parsing.
  assert property (@(posedge clk) disable iff (rst)
    accept && element_start |=> header_position == 3'd1 && !element_finished)
    else $error("start byte did not restart header parsing");

  // Results only come from accepted payload bytes, never from a start byte.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> accept && !element_start && header_position >= HDR_PAYLOAD)
    else $error("result produced outside the payload");

  // Bytes of a finished element leave the sample counters alone.
  assert property (@(posedge clk) disable iff (rst)
    accept && !element_start && element_finished |=>
      $stable(samples_seen) && $stable(word_channel))
    else $error("finished element still advanced");

  // After the last sample on channel 7 in multi-channel mode the element is finished.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.last_of_element && !cfg.single_channel_mode &&
      word_channel == CH_W'(CHANNELS - 1) |=> element_finished)
    else $error("element not finished after its last sample");
`endif

endmodule : aes3pcm_parse
`default_nettype wire

// ----- src/aes3pcm_out_buf.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// AES3 element to PCM: output buffer
// Output register with a skid entry, so the input keeps flowing while one
// result waits for the downstream side.
// ---------------------------------------------------------------------------
module aes3pcm_out_buf
  import aes3pcm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  result_t   push_data,
  output logic      space,
  output logic      out_valid,
  input  wire logic out_ready,
  output result_t   out_data
);

  logic    head_valid;
  logic    skid_valid;
  result_t head;
  result_t skid;
  logic    pop;

  assign pop = head_valid && out_ready;

  // Head and skid update; push never arrives while the skid is occupied.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        head_valid <= push;
      end
    end else if (push) begin
      if (head_valid) begin
        skid_valid <= 1'b1;
      end else begin
        head_valid <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        head <= skid;
      end else if (push) begin
        head <= push_data;
      end
    end else if (push) begin
      if (head_valid) begin
        skid <= push_data;
      end else begin
        head <= push_data;
      end
    end
  end

  assign space     = !skid_valid;
  assign out_valid = head_valid;
  assign out_data  = head;

`ifndef NO_ASSERTIONS
  // The skid entry is only used behind a valid head.
  assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> head_valid)
    else $error("skid entry filled with empty head");

  // A push is only made while there is room.
  assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("push into a full buffer");

  // A stalled head with a waiting skid keeps both entries.
  assert property (@(posedge clk) disable iff (rst)
    head_valid && !out_ready && skid_valid |=> skid_valid && $stable(head))
    else $error("buffered result lost during stall");
`endif

endmodule : aes3pcm_out_buf
`default_nettype wire

// ----- src/aes3_element_to_pcm_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// AES3 element to PCM unit
// Turns a byte stream of eight-channel AES3 elements into PCM samples.
//
//   Channel   Dir  Fields (low bit up)
//   s_axis    in   tdata: element_byte[7:0]; tuser: element_start
//   m_axis    out  tdata: pcm_sample[23:0], channel_index[26:24], zero pad;
//                  tlast: last_of_element
//   cfg       in   index 0..3: sample_bytes, single_channel_mode,
//                  selected_channel, lead channel count
//
// One byte is accepted per cycle while s_axis_tready is high; a sample is
// registered into a two-entry output buffer when its final word byte is accepted.
// s_axis_tready drops only while both buffer entries hold results.
// Synchronous reset clears the parser to idle (waiting for a start byte)
// and loads the register defaults; no clearing pass is needed.
// ---------------------------------------------------------------------------
module aes3_element_to_pcm_unit
  import aes3pcm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Input byte stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // element_byte[7:0]
  input  wire logic        s_axis_tuser,   // element_start
  // Output sample stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // pcm_sample[23:0], channel_index[26:24]
  output logic             m_axis_tlast,
  // Configuration write port.
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_wdata
);

  cfg_t    cfg;
  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_data;

  // Input transaction handshake.
  assign accept = s_axis_tvalid && s_axis_tready;

  aes3pcm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  aes3pcm_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .element_byte  (s_axis_tdata),
    .element_start (s_axis_tuser),
    .cfg           (cfg),
    .res_valid     (res_valid),
    .res           (res)
  );

  aes3pcm_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .space     (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data)
  );

  // Output packing.
  assign m_axis_tdata = {5'b0, out_data.channel_index, out_data.pcm_sample};
  assign m_axis_tlast = out_data.last_of_element;

endmodule : aes3_element_to_pcm_unit
`default_nettype wire

// ----- tb/sv/aes3_element_to_pcm_unit_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// AES3 element to PCM unit: self-checking testbench
// Streams AES3 elements into the unit byte by byte and checks every PCM
// sample it emits against a cycle-free model of the element parser. A short
// directed table is followed by phases of random elements, each under its
// own register setting, with bursty input and a stalling sample sink.
// ---------------------------------------------------------------------------
module aes3_element_to_pcm_unit_test;
  import aes3pcm_pkg::*;

  localparam int  HALF_PERIOD  = 4;
  localparam int  RESET_CYCLES = 9;
  localparam int  BYTE_GOAL    = 1750;
  localparam int  PHASE_BYTES  = 160;
  localparam int  HOLD_CYCLES  = 400;
  localparam int  DRAIN_CYCLES = 8;
  localparam int  LIMIT_CYCLES = 400000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tuser = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic       cfg_wr_en = 1'b0;
  cfg_reg_t   cfg_index = REG_SAMPLE_BYTES;
  logic [3:0] cfg_wdata = 4'h0;

  aes3_element_to_pcm_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // element_byte[7:0]
    .s_axis_tuser  (s_axis_tuser),   // element_start
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // pcm_sample[23:0], channel_index[26:24]
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // Register copies held by the parser model.
  logic [1:0]  cfg_sample_bytes = SAMPLE_BYTES_RST;
  logic        cfg_single       = 1'b0;
  logic [2:0]  cfg_selected     = 3'd0;
  logic [3:0]  cfg_count        = LEAD_CHANNELS_RST;

  // Parser model state.
  logic [2:0]  hdr_pos      = 3'd0;
  logic [15:0] sample_total = 16'h0000;
  logic [7:0]  valid_mask   = 8'h00;
  logic [15:0] samples_done = 16'h0000;
  logic [2:0]  word_ch      = 3'd0;
  logic [1:0]  word_pos     = 2'd0;
  logic [23:0] word_low     = 24'h000000;
  logic        elem_done    = 1'b1;

  result_t pending_samples[$];

  int  mismatch_count  = 0;
  int  samples_checked = 0;
  int  bytes_sent      = 0;
  int  bytes_parsed    = 0;
  int  cycle_count     = 0;
  int  burst_left      = 0;
  bit  steady_phase    = 1'b0;
  bit  hold_request    = 1'b0;

  // Advances the parser model by one byte. Returns 1 when the byte completes
  // an emitted channel word; parsed is 0 for a byte that the unit ignores.
  function automatic bit decode_byte(input logic [7:0] b, input logic st,
                                     output result_t smp, output bit parsed);
    logic [31:0] word;
    logic [23:0] value;
    int          limit;
    int          last_ch;
    bit          emit;
    smp = '0;
    parsed = 1'b1;
    if (st) begin
      hdr_pos      = 3'd1;
      sample_total = '0;
      valid_mask   = '0;
      samples_done = '0;
      word_ch      = '0;
      word_pos     = '0;
      word_low     = '0;
      elem_done    = 1'b0;
      return 1'b0;
    end
    if (elem_done) begin
      parsed = 1'b0;
      return 1'b0;
    end
    // Header bytes: count low, count high, then the valid mask.
    if (hdr_pos < HDR_PAYLOAD) begin
      case (hdr_pos)
        3'd1: sample_total[7:0] = b;
        3'd2: sample_total[15:8] = b;
        default: begin
          valid_mask = b;
          if (sample_total == 16'h0000) elem_done = 1'b1;
        end
      endcase
      hdr_pos = hdr_pos + 3'd1;
      return 1'b0;
    end
    if (word_pos < WORD_LAST_POS) begin
      word_low[8*word_pos +: 8] = b;
      word_pos = word_pos + 2'd1;
      return 1'b0;
    end

    // Final byte of a channel word: extract the sample.
    word = {b, word_low};
    if (cfg_sample_bytes == SAMPLE_BYTES_16) value = {8'h00, word[27:12]};
    else value = word[27:4];
    if (!valid_mask[word_ch]) value = '0;

    limit = (cfg_count > LEAD_CHANNELS_MAX) ? int'(LEAD_CHANNELS_MAX) : int'(cfg_count);
    if (cfg_single) begin
      emit = (word_ch == cfg_selected);
      last_ch = int'(cfg_selected);
    end else begin
      emit = (int'(word_ch) < limit);
      last_ch = limit - 1;
    end
    smp.pcm_sample      = value;
    smp.channel_index   = word_ch;
    smp.last_of_element = emit && (int'(word_ch) == last_ch) &&
                          (int'(samples_done) + 1 == int'(sample_total));

    word_pos = '0;
    word_low = '0;
    word_ch  = word_ch + 3'd1;
    if (word_ch == 3'd0) begin
      samples_done = samples_done + 16'd1;
      if (samples_done == sample_total) elem_done = 1'b1;
    end
    return emit;
  endfunction

  // Offers one byte as a transaction and records what it should produce.
  // Bursts of random length are separated by random gaps.
  task automatic push_byte(input logic [7:0] b, input logic st, input bit typed,
                           input result_t want);
    int      gap;
    result_t smp;
    bit      parsed;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady_phase || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= st;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
    if (decode_byte(b, st, smp, parsed)) pending_samples.push_back(typed ? want : smp);
    if (parsed) bytes_parsed++;
  endtask

  // Stops offering bytes and waits until every expected sample has left.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [3:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_SAMPLE_BYTES:        cfg_sample_bytes = val[1:0];
      REG_SINGLE_CHANNEL_MODE: cfg_single       = val[0];
      REG_SELECTED_CHANNEL:    cfg_selected     = val[2:0];
      REG_LEAD_CHANNELS:       cfg_count        = val;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [3:0] sb, input logic [3:0] single,
                               input logic [3:0] sel, input logic [3:0] cnt);
    write_reg(REG_SAMPLE_BYTES, sb);
    write_reg(REG_SINGLE_CHANNEL_MODE, single);
    write_reg(REG_SELECTED_CHANNEL, sel);
    write_reg(REG_LEAD_CHANNELS, cnt);
    cfg_wr_en <= 1'b0;
  endtask

  // One element: start byte, header, counted channel words, trailing bytes.
  // A broken element stops at a random byte and is cut off by the next start.
  task automatic send_element(input bit broken);
    logic [15:0] count;
    logic [7:0]  mask;
    logic [7:0]  b;
    logic [31:0] word;
    int          pick;
    int          len;
    int          cut;
    word = '0;
    pick = $urandom_range(0, 9);
    if (broken && pick < 5) count = 16'($urandom_range(0, 65535));
    else if (pick == 0) count = 16'h0000;
    else if (pick < 8) count = 16'($urandom_range(1, 3));
    else count = 16'($urandom_range(4, 12));
    pick = $urandom_range(0, 7);
    mask = (pick == 0) ? 8'hFF : (pick == 1) ? 8'h00 : 8'($urandom_range(0, 255));
    len = (count > 16'd12) ? 80 : 4 + 32 * int'(count);
    cut = broken ? $urandom_range(1, (len - 1 < 80) ? len - 1 : 80) : len;

    push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
    for (int k = 1; k < cut; k++) begin
      if (k == 1) b = count[7:0];
      else if (k == 2) b = count[15:8];
      else if (k == 3) b = mask;
      else begin
        // New channel word: mostly random, sometimes an extreme pattern.
        if ((k - 4) % 4 == 0) begin
          pick = $urandom_range(0, 7);
          if (pick == 5) word = 32'hFFFF_FFFF;
          else if (pick == 6) word = 32'h0000_0000;
          else if (pick == 7) word = 32'h1 << $urandom_range(0, 31);
          else word = $urandom;
        end
        b = word[8*((k - 4) % 4) +: 8];
      end
      push_byte(b, 1'b0, 1'b0, '0);
    end
    if (!broken) begin
      repeat ($urandom_range(0, 5)) push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
    end
  endtask

  // Sample sink: checks each transaction and stalls on its own pattern.
  initial begin : sample_sink
    result_t want;
    int      mode;
    int      mode_left;
    int      hold_left;
    int      tick;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        if (pending_samples.size() == 0) begin
          $error("Sample with no expectation: tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast);
          mismatch_count++;
        end else begin
          want = pending_samples.pop_front();
          samples_checked++;
          if (m_axis_tdata[23:0] !== want.pcm_sample) begin
            $error("pcm_sample: expected %h, got %h", want.pcm_sample, m_axis_tdata[23:0]);
            mismatch_count++;
          end
          if (m_axis_tdata[26:24] !== want.channel_index) begin
            $error("channel_index: expected %0d, got %0d",
                   want.channel_index, m_axis_tdata[26:24]);
            mismatch_count++;
          end
          if (m_axis_tlast !== want.last_of_element) begin
            $error("last_of_element: expected %b, got %b", want.last_of_element, m_axis_tlast);
            mismatch_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 7) == 0);
          default: m_axis_tready <= (tick % 5 != 0);
        endcase
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $error("Run did not finish within %0d cycles", LIMIT_CYCLES);
      $display("Mismatches found");
      $finish;
    end
  end

  typedef struct {
    logic [7:0] b;
    logic       st;
    bit         typed;
    result_t    want;
  } stim_row_t;

  initial begin : stimulus
    stim_row_t   plan[25];
    logic [3:0]  fixed_sb[8];
    logic [3:0]  fixed_single[8];
    logic [3:0]  fixed_sel[8];
    logic [3:0]  fixed_cnt[8];
    int          phase;
    int          phase_start;
    int          pick;

    // Directed table, run under the reset register values. Rows cover idle
    // bytes, a zero-count element, trailing bytes, a restart in the middle of
    // a header, extreme words and an invalid channel.
    plan = '{
      '{8'h00, 1'b0, 1'b0, '0},                        // ignored while idle
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hA5, 1'b1, 1'b0, '0},                        // element with no samples
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h37, 1'b0, 1'b0, '0},                        // trailing byte
      '{8'h00, 1'b1, 1'b0, '0},                        // header cut short
      '{8'h02, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b1, 1'b0, '0},                        // restart: 1 sample,
      '{8'h01, 1'b0, 1'b0, '0},                        // channel 1 invalid
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'hFD, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},                        // channel 0: all ones
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b1, '{1'b0, 3'd0, 24'hFFFFFF}},
      '{8'hFF, 1'b0, 1'b0, '0},                        // channel 1: masked off
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b1, '{1'b0, 3'd1, 24'h000000}},
      '{8'h78, 1'b0, 1'b0, '0},                        // channel 2: mixed bits
      '{8'h56, 1'b0, 1'b0, '0},
      '{8'h34, 1'b0, 1'b0, '0},
      '{8'h12, 1'b0, 1'b0, '0}
    };

    // Settings for the first phases: both sample sizes, odd size codes, both
    // modes, channel counts of zero, one, eight and above eight.
    fixed_sb     = '{4'd3, 4'd2, 4'd2, 4'd3, 4'd0, 4'd1, 4'hF, 4'd2};
    fixed_single = '{4'd0, 4'd0, 4'd1, 4'd1, 4'd0, 4'd0, 4'hE, 4'd0};
    fixed_sel    = '{4'd0, 4'd0, 4'd7, 4'd0, 4'd0, 4'd0, 4'hF, 4'd5};
    fixed_cnt    = '{4'd8, 4'd8, 4'd8, 4'd8, 4'd0, 4'hF, 4'd1, 4'd9};

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) push_byte(plan[i].b, plan[i].st, plan[i].typed, plan[i].want);

    // Random phases, each under one register setting.
    phase = 0;
    while (bytes_sent < BYTE_GOAL) begin
      settle();
      if (phase < 8) load_settings(fixed_sb[phase], fixed_single[phase],
                                   fixed_sel[phase], fixed_cnt[phase]);
      else load_settings(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                         4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      steady_phase = (phase % 4 == 1);
      // Long sink hold-off while input keeps coming, so the unit backs up.
      if (phase == 3) hold_request = 1'b1;
      phase_start = bytes_parsed;
      while (bytes_parsed - phase_start < PHASE_BYTES) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) send_element(1'b0);
        else if (pick < 9) send_element(1'b1);
        else begin
          repeat ($urandom_range(1, 6)) begin
            push_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 9) == 0), 1'b0, '0);
          end
        end
      end
      phase++;
    end
    settle();

    $display("Sent %0d bytes (%0d parsed) over %0d register settings; %0d samples checked.",
             bytes_sent, bytes_parsed, phase, samples_checked);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
